### hdl/obbc_pkg.sv
// ----------------------------------------------------------------------------
// Oriented box pair collision: shared package
// Sizes, the stored box record, result record and controller/datapath links.
// ----------------------------------------------------------------------------
package obbc_pkg;

    localparam int MAX_BOXES = 32;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);
    localparam int IDX_W     = $clog2(MAX_BOXES);
    localparam int AW        = 41;
    localparam int BW        = 18;
    localparam int PCNT_W    = 5;
    localparam logic [PCNT_W-1:0] PROJ_LAST = PCNT_W'(16);

    typedef struct packed {
        logic [15:0]        entity;
        logic               imm;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] rmin_x;
        logic signed [31:0] rmin_y;
        logic signed [31:0] rmax_x;
        logic signed [31:0] rmax_y;
        logic signed [15:0] cs;
        logic signed [15:0] sn;
        logic [30:0]        radius;
    } t_box;

    typedef struct packed {
        logic [15:0]        earlier;
        logic [15:0]        newer;
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic [30:0]        depth;
    } t_res;

    typedef struct packed {
        logic              in_ready;
        logic              load_in;
        logic              prep;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              circ1;
        logic              circ2;
        logic              proj;
        logic [PCNT_W-1:0] pcnt;
        logic              pass;
        logic              ovl;
        logic              sat;
        logic              pick;
        logic              px;
        logic              py;
        logic              fin;
        logic              emit;
        logic              flush;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_first;
        logic circ_skip;
        logic circ_far;
        logic sat_fail;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

### hdl/obbc_if.sv
// ----------------------------------------------------------------------------
// Oriented box pair collision: channel interfaces
// Box request channel and collision result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface obbc_box_if;
    logic               valid;
    logic               ready;
    logic               first_of_set;
    logic [15:0]        entity_id;
    logic               immovable;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic [30:0]        bound_radius;

    modport source (output valid, first_of_set, entity_id, immovable, pivot_x, pivot_y,
                    min_x, min_y, max_x, max_y, cos_angle, sin_angle, bound_radius,
                    input ready);
    modport sink (input valid, first_of_set, entity_id, immovable, pivot_x, pivot_y,
                  min_x, min_y, max_x, max_y, cos_angle, sin_angle, bound_radius,
                  output ready);
endinterface

interface obbc_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        earlier_entity;
    logic [15:0]        newer_entity;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [30:0]        depth;
    logic               last;

    modport source (output valid, earlier_entity, newer_entity, push_x, push_y,
                    normal_x, normal_y, depth, last, input ready);
    modport sink (input valid, earlier_entity, newer_entity, push_x, push_y,
                  normal_x, normal_y, depth, last, output ready);
endinterface

### hdl/oriented_box_pair_collision.sv
// ----------------------------------------------------------------------------
// Oriented box pair collision
// Tests each incoming 2D oriented box against the boxes stored for the
// current set and reports a push vector, unit normal and depth per collision.
//
//   Port        Dir  Handshake    Carries
//   i_box       in   valid/ready  one box request
//   o_res       out  valid/ready  one collision result, last marks the final
//   i_cfg_wr_*  in   write enable zero tolerance register
//
// A request walks the stored boxes. A pair ends early when it is
// rejected by the immovable check or the bounding circles, or when the
// first overlap test fails, and otherwise runs the full test through the
// single shared rotation unit, one corner at a time.
// A request that arrives with a full table is dropped.
// Reset is synchronous and empties the table. A stalled result stalls the
// walk only when a second result is waiting behind it.
// ----------------------------------------------------------------------------
module oriented_box_pair_collision (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    obbc_box_if.sink    i_box,
    obbc_res_if.source  o_res
);
    import obbc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    obbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    obbc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_box         (i_box),
        .o_res         (o_res)
    );

endmodule

### hdl/obbc_dp.sv
// ----------------------------------------------------------------------------
// Oriented box pair collision: datapath
// Box table, bounding circle test, shared rotation unit, overlap tests and
// the result holding and output registers.
// ----------------------------------------------------------------------------
module obbc_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data,
    input  obbc_pkg::t_cmd i_cmd,
    output obbc_pkg::t_sts o_sts,
    obbc_box_if.sink      i_box,
    obbc_res_if.source    o_res
);
    import obbc_pkg::*;

    function automatic logic signed [31:0] f_sat32(input logic signed [AW:0] v);
        logic signed [31:0] r;
        begin
            if (v > $signed((AW+1)'(32'sh7FFFFFFF))) r = 32'sh7FFFFFFF;
            else if (v < $signed(-(AW+1)'(64'sh80000000))) r = 32'sh80000000;
            else r = v[31:0];
            return r;
        end
    endfunction

    function automatic logic signed [31:0] f_rel(input logic signed [31:0] a,
                                                 input logic signed [31:0] c);
        logic signed [32:0] d;
        logic signed [31:0] r;
        begin
            d = 33'(a) - 33'(c);
            if (d[32] != d[31]) r = d[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
            else r = d[31:0];
            return r;
        end
    endfunction

    function automatic logic signed [AW-1:0] f_abs(input logic signed [AW-1:0] v);
        return v[AW-1] ? -v : v;
    endfunction

    function automatic logic signed [AW-1:0] f_overlap(input logic signed [AW-1:0] mn0,
        input logic signed [AW-1:0] mx0, input logic signed [AW-1:0] mn1,
        input logic signed [AW-1:0] mx1);
        logic signed [AW-1:0] r;
        begin
            if (mn1 > mx0 || mx1 < mn0) r = '0;
            else if (mx0 > mx1) r = mn0 - mx1;
            else r = mx0 - mn1;
            return r;
        end
    endfunction

    function automatic logic signed [15:0] f_satn(input logic signed [BW-1:0] v);
        logic signed [15:0] r;
        begin
            if (v > BW'(16384)) r = 16'sd16384;
            else if (v < -BW'(16384)) r = -16'sd16384;
            else r = v[15:0];
            return r;
        end
    endfunction

    t_box r_mem [MAX_BOXES];
    t_box r_in, r_nb, r_rd;
    logic [15:0] r_tol;

    logic [31:0] r_rsum;
    logic [32:0] r_adx, r_ady;
    logic signed [32:0] r_dcx, r_dcy;
    logic r_imm_skip;
    logic [63:0] r_r2, r_dx2, r_dy2;

    logic signed [AW-1:0] r_x1, r_y1, r_ex, r_ey;
    logic signed [AW-1:0] r_mnx, r_mxx, r_mny, r_mxy;
    logic signed [AW-1:0] r_xo, r_yo, r_p0, r_p1, r_ov, r_px, r_py;
    logic r_a0, r_a1, r_axis, r_pick0;
    logic signed [15:0] r_pc, r_ps;

    t_res r_res, r_pend, r_out;
    logic r_pend_v, r_out_v, r_out_last;

    t_box w_a, w_b, w_nb;
    logic [1:0] w_k, w_step;
    logic signed [AW-1:0] w_dcx, w_dcy, w_cx, w_cy, w_xx, w_yy;
    logic signed [AW-1:0] w_ra0, w_ra1, w_rot;
    logic signed [BW-1:0] w_rb0, w_rb1;
    logic signed [AW+BW:0] w_acc;
    logic signed [AW-1:0] w_tol, w_axo, w_ayo;
    logic w_fail, w_xwin, w_pick0, w_neg;
    logic signed [AW:0] w_pxs, w_pys;
    logic signed [BW-1:0] w_nx, w_ny;
    logic signed [AW-1:0] w_dep;
    t_res w_fin;

    assign w_a    = i_cmd.pass ? r_nb : r_rd;
    assign w_b    = i_cmd.pass ? r_rd : r_nb;
    assign w_k    = i_cmd.pcnt[3:2];
    assign w_step = i_cmd.pcnt[1:0];
    assign w_dcx  = i_cmd.pass ? -AW'(r_dcx) : AW'(r_dcx);
    assign w_dcy  = i_cmd.pass ? -AW'(r_dcy) : AW'(r_dcy);
    assign w_cx   = (w_k == 2'd0 || w_k == 2'd3) ? AW'(w_a.rmin_x) : AW'(w_a.rmax_x);
    assign w_cy   = w_k[1] ? AW'(w_a.rmax_y) : AW'(w_a.rmin_y);
    assign w_xx   = r_x1 + w_dcx;
    assign w_yy   = r_y1 + w_dcy;

    always_comb begin
        w_nb        = r_in;
        w_nb.rmin_x = f_rel(r_in.rmin_x, r_in.cx);
        w_nb.rmin_y = f_rel(r_in.rmin_y, r_in.cy);
        w_nb.rmax_x = f_rel(r_in.rmax_x, r_in.cx);
        w_nb.rmax_y = f_rel(r_in.rmax_y, r_in.cy);
    end

    always_comb begin
        w_ra0 = '0;
        w_ra1 = '0;
        w_rb0 = '0;
        w_rb1 = '0;
        if (i_cmd.proj) begin
            case (w_step)
                2'd0: begin
                    w_ra0 = w_cx; w_rb0 = BW'(w_a.cs);
                    w_ra1 = w_cy; w_rb1 = -BW'(w_a.sn);
                end
                2'd1: begin
                    w_ra0 = w_cx; w_rb0 = BW'(w_a.sn);
                    w_ra1 = w_cy; w_rb1 = BW'(w_a.cs);
                end
                2'd2: begin
                    w_ra0 = w_xx; w_rb0 = BW'(w_b.cs);
                    w_ra1 = w_yy; w_rb1 = BW'(w_b.sn);
                end
                default: begin
                    w_ra0 = w_xx; w_rb0 = -BW'(w_b.sn);
                    w_ra1 = w_yy; w_rb1 = BW'(w_b.cs);
                end
            endcase
        end else if (i_cmd.px) begin
            w_ra0 = r_ov;
            w_rb0 = r_axis ? -BW'(r_ps) : BW'(r_pc);
        end else if (i_cmd.py) begin
            w_ra0 = r_ov;
            w_rb0 = r_axis ? BW'(r_pc) : BW'(r_ps);
        end
    end

    // Rotation rounds half up: add half an LSB, then floor by arithmetic shift.
    assign w_acc = w_ra0 * w_rb0 + w_ra1 * w_rb1 + 8192;
    assign w_rot = AW'(w_acc >>> 14);

    assign w_tol   = $signed({{(AW-16){1'b0}}, r_tol});
    assign w_axo   = f_abs(r_xo);
    assign w_ayo   = f_abs(r_yo);
    assign w_fail  = (w_axo <= w_tol) || (w_ayo <= w_tol);
    assign w_xwin  = w_axo <= w_ayo;
    assign w_pick0 = f_abs(r_p0) <= f_abs(r_p1);

    assign w_neg = r_pick0 ^ r_ov[AW-1];
    assign w_pxs = r_pick0 ? -(AW+1)'(r_px) : (AW+1)'(r_px);
    assign w_pys = r_pick0 ? -(AW+1)'(r_py) : (AW+1)'(r_py);
    assign w_dep = f_abs(r_ov);

    always_comb begin
        if (r_axis) begin
            w_nx = -BW'(r_ps);
            w_ny = BW'(r_pc);
        end else begin
            w_nx = BW'(r_pc);
            w_ny = BW'(r_ps);
        end
        if (w_neg) begin
            w_nx = -w_nx;
            w_ny = -w_ny;
        end
        w_fin.earlier  = r_rd.entity;
        w_fin.newer    = r_nb.entity;
        w_fin.push_x   = f_sat32(w_pxs);
        w_fin.push_y   = f_sat32(w_pys);
        w_fin.normal_x = f_satn(w_nx);
        w_fin.normal_y = f_satn(w_ny);
        w_fin.depth    = (w_dep > AW'(32'sh7FFFFFFF)) ? 31'h7FFFFFFF : w_dep[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_addr];
        end
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= r_nb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in.entity <= i_box.entity_id;
            r_in.imm    <= i_box.immovable;
            r_in.cx     <= i_box.pivot_x;
            r_in.cy     <= i_box.pivot_y;
            r_in.rmin_x <= i_box.min_x;
            r_in.rmin_y <= i_box.min_y;
            r_in.rmax_x <= i_box.max_x;
            r_in.rmax_y <= i_box.max_y;
            r_in.cs     <= i_box.cos_angle;
            r_in.sn     <= i_box.sin_angle;
            r_in.radius <= i_box.bound_radius;
        end
        if (i_cmd.prep) begin
            r_nb <= w_nb;
        end
        if (i_cmd.circ1) begin
            r_rsum     <= 32'(r_rd.radius) + 32'(r_nb.radius);
            r_dcx      <= 33'(r_rd.cx) - 33'(r_nb.cx);
            r_dcy      <= 33'(r_rd.cy) - 33'(r_nb.cy);
            r_adx      <= (r_rd.cx < r_nb.cx) ? 33'(r_nb.cx) - 33'(r_rd.cx)
                                              : 33'(r_rd.cx) - 33'(r_nb.cx);
            r_ady      <= (r_rd.cy < r_nb.cy) ? 33'(r_nb.cy) - 33'(r_rd.cy)
                                              : 33'(r_rd.cy) - 33'(r_nb.cy);
            r_imm_skip <= r_rd.imm & r_nb.imm;
        end
        if (i_cmd.circ2) begin
            r_r2  <= r_rsum * r_rsum;
            r_dx2 <= r_adx[31:0] * r_adx[31:0];
            r_dy2 <= r_ady[31:0] * r_ady[31:0];
        end
        if (i_cmd.proj) begin
            case (w_step)
                2'd0:    r_x1 <= w_rot;
                2'd1:    r_y1 <= w_rot;
                2'd2:    r_ex <= w_rot;
                default: r_ey <= w_rot;
            endcase
            if (w_step == 2'd3) begin
                if (i_cmd.pcnt == PCNT_W'(3) || r_ex < r_mnx) r_mnx <= r_ex;
                if (i_cmd.pcnt == PCNT_W'(3) || r_ex > r_mxx) r_mxx <= r_ex;
            end
            if (w_step == 2'd0 && i_cmd.pcnt != '0) begin
                if (i_cmd.pcnt == PCNT_W'(4) || r_ey < r_mny) r_mny <= r_ey;
                if (i_cmd.pcnt == PCNT_W'(4) || r_ey > r_mxy) r_mxy <= r_ey;
            end
        end
        if (i_cmd.ovl) begin
            r_xo <= f_overlap(AW'(w_b.rmin_x), AW'(w_b.rmax_x), r_mnx, r_mxx);
            r_yo <= f_overlap(AW'(w_b.rmin_y), AW'(w_b.rmax_y), r_mny, r_mxy);
        end
        if (i_cmd.sat) begin
            if (i_cmd.pass) begin
                r_p1 <= w_xwin ? -r_xo : -r_yo;
                r_a1 <= !w_xwin;
            end else begin
                r_p0 <= w_xwin ? -r_xo : -r_yo;
                r_a0 <= !w_xwin;
            end
        end
        if (i_cmd.pick) begin
            r_pick0 <= w_pick0;
            r_ov    <= w_pick0 ? r_p0 : r_p1;
            r_axis  <= w_pick0 ? r_a0 : r_a1;
            r_pc    <= w_pick0 ? r_nb.cs : r_rd.cs;
            r_ps    <= w_pick0 ? r_nb.sn : r_rd.sn;
        end
        if (i_cmd.px) begin
            r_px <= w_rot;
        end
        if (i_cmd.py) begin
            r_py <= w_rot;
        end
        if (i_cmd.fin) begin
            r_res <= w_fin;
        end
        if (i_cmd.emit) begin
            r_pend <= r_res;
        end
        if ((i_cmd.emit && r_pend_v) || i_cmd.flush) begin
            r_out      <= r_pend;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tol <= i_cfg_wr_data;
            end
            if (i_cmd.emit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if ((i_cmd.emit && r_pend_v) || i_cmd.flush) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign i_box.ready = i_cmd.in_ready;

    assign o_res.valid          = r_out_v;
    assign o_res.earlier_entity = r_out.earlier;
    assign o_res.newer_entity   = r_out.newer;
    assign o_res.push_x         = r_out.push_x;
    assign o_res.push_y         = r_out.push_y;
    assign o_res.normal_x       = r_out.normal_x;
    assign o_res.normal_y       = r_out.normal_y;
    assign o_res.depth          = r_out.depth;
    assign o_res.last           = r_out_last;

    assign o_sts.in_valid   = i_box.valid;
    assign o_sts.in_first   = i_box.first_of_set;
    assign o_sts.circ_skip  = r_imm_skip || (r_adx >= {1'b0, r_rsum})
                              || (r_ady >= {1'b0, r_rsum});
    assign o_sts.circ_far   = r_dy2 >= (r_r2 - r_dx2);
    assign o_sts.sat_fail   = w_fail;
    assign o_sts.pend_valid = r_pend_v;
    assign o_sts.out_free   = !r_out_v || o_res.ready;

endmodule

### hdl/obbc_ctrl.sv
// ----------------------------------------------------------------------------
// Oriented box pair collision: controller
// Walks the stored boxes for each request and sequences the datapath.
// ----------------------------------------------------------------------------
module obbc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  obbc_pkg::t_sts i_sts,
    output obbc_pkg::t_cmd o_cmd
);
    import obbc_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'd1,
        S_PREP  = 17'd1 << 1,
        S_READ  = 17'd1 << 2,
        S_CIRC1 = 17'd1 << 3,
        S_CIRC2 = 17'd1 << 4,
        S_CIRC3 = 17'd1 << 5,
        S_PROJ  = 17'd1 << 6,
        S_OVL   = 17'd1 << 7,
        S_SAT   = 17'd1 << 8,
        S_PICK  = 17'd1 << 9,
        S_PX    = 17'd1 << 10,
        S_PY    = 17'd1 << 11,
        S_FIN   = 17'd1 << 12,
        S_EMIT  = 17'd1 << 13,
        S_NEXT  = 17'd1 << 14,
        S_FLUSH = 17'd1 << 15,
        S_STORE = 17'd1 << 16
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count, r_idx, n_idx;
    logic [PCNT_W-1:0] r_pcnt, n_pcnt;
    logic r_pass, n_pass;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_pcnt  = r_pcnt;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_cmd.rd_addr = r_idx[IDX_W-1:0];
        o_cmd.wr_addr = r_count[IDX_W-1:0];
        o_cmd.pcnt    = r_pcnt;
        o_cmd.pass    = r_pass;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_sts.in_first) begin
                        n_count = '0;
                    end
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_idx = '0;
                if (r_count == CNT_W'(MAX_BOXES)) begin
                    n_state = S_IDLE;
                end else if (r_count == '0) begin
                    n_state = S_FLUSH;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_CIRC1;
            end
            S_CIRC1: begin
                o_cmd.circ1 = 1'b1;
                n_state = S_CIRC2;
            end
            S_CIRC2: begin
                o_cmd.circ2 = 1'b1;
                n_state = i_sts.circ_skip ? S_NEXT : S_CIRC3;
            end
            S_CIRC3: begin
                n_pcnt = '0;
                n_pass = 1'b0;
                n_state = i_sts.circ_far ? S_NEXT : S_PROJ;
            end
            S_PROJ: begin
                o_cmd.proj = 1'b1;
                if (r_pcnt == PROJ_LAST) begin
                    n_state = S_OVL;
                end else begin
                    n_pcnt = r_pcnt + 1'b1;
                end
            end
            S_OVL: begin
                o_cmd.ovl = 1'b1;
                n_state = S_SAT;
            end
            S_SAT: begin
                if (i_sts.sat_fail) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.sat = 1'b1;
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_pcnt  = '0;
                        n_state = S_PROJ;
                    end else begin
                        n_state = S_PICK;
                    end
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state = S_PX;
            end
            S_PX: begin
                o_cmd.px = 1'b1;
                n_state = S_PY;
            end
            S_PY: begin
                o_cmd.py = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                n_idx = r_idx + 1'b1;
                n_state = (n_idx == r_count) ? S_FLUSH : S_READ;
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_STORE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.wr_en = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pcnt  <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pcnt  <= n_pcnt;
            r_pass  <= n_pass;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BOXES))
        else $error("box count beyond table size");

    a_read_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_idx < r_count))
        else $error("read of an entry outside the table");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_sts.pend_valid && !i_sts.out_free) |=> (r_state == S_EMIT))
        else $error("result dropped while output register busy");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STORE) |=> (r_count == $past(r_count) + 1'b1))
        else $error("stored box not counted");

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// Oriented box pair collision: regression testbench
// Drives box requests through the request channel, predicts every collision
// result with an independent fixed-point model of the separating axis test,
// and checks each result field by field, with random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import obbc_pkg::*;

    typedef struct packed {
        logic               first_of_set;
        logic [15:0]        entity_id;
        logic               immovable;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic [30:0]        bound_radius;
    } t_req;

    typedef struct packed {
        t_res res;
        logic last;
    } t_expected;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    obbc_box_if box_ch ();
    obbc_res_if res_ch ();

    oriented_box_pair_collision dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_box        (box_ch.sink),
        .o_res        (res_ch.source)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: the table of boxes held for the current set.
    int unsigned    tolerance;
    int unsigned    table_count;
    logic [15:0]    tbl_entity [MAX_BOXES];
    logic           tbl_imm [MAX_BOXES];
    longint         tbl_c [MAX_BOXES][2];
    longint         tbl_r [MAX_BOXES][4];
    longint         tbl_rt [MAX_BOXES][2];
    longint         tbl_rad [MAX_BOXES];

    t_expected      collisions_due[$];
    int             errors = 0;
    bit             quiet_mode = 0;
    bit             hold_off = 0;
    int             idle_cycles = 0;
    bit             timed_out = 0;

    function automatic longint floor14(longint v);
        return v >>> 14;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint span_overlap(longint mn0, longint mx0, longint mn1, longint mx1);
        if (mn1 > mx0 || mx1 < mn0) return 0;
        return mx0 > mx1 ? mn0 - mx1 : mx0 - mn1;
    endfunction

    // Corners of box a moved into the frame of box b.
    task automatic corners_in_frame(input longint ra[4], input longint ca[2],
                                    input longint rta[2], input longint cb[2],
                                    input longint rtb[2], output longint ex[4],
                                    output longint ey[4]);
        longint px[4];
        longint py[4];
        longint x, y;
        px = '{ra[0], ra[2], ra[2], ra[0]};
        py = '{ra[1], ra[1], ra[3], ra[3]};
        for (int k = 0; k < 4; k++) begin
            x = floor14(px[k] * rta[0] - py[k] * rta[1] + 8192) + ca[0] - cb[0];
            y = floor14(px[k] * rta[1] + py[k] * rta[0] + 8192) + ca[1] - cb[1];
            ex[k] = floor14(x * rtb[0] + y * rtb[1] + 8192);
            ey[k] = floor14(-x * rtb[1] + y * rtb[0] + 8192);
        end
    endtask

    task automatic axis_overlap(input longint rb[4], input longint ex[4], input longint ey[4],
                                output bit hit, output longint push, output int axis);
        longint mnx, mxx, mny, mxy, xo, yo;
        mnx = ex[0]; mxx = ex[0]; mny = ey[0]; mxy = ey[0];
        hit = 0; push = 0; axis = 0;
        for (int k = 1; k < 4; k++) begin
            if (ex[k] < mnx) mnx = ex[k];
            if (ex[k] > mxx) mxx = ex[k];
            if (ey[k] < mny) mny = ey[k];
            if (ey[k] > mxy) mxy = ey[k];
        end
        xo = span_overlap(rb[0], rb[2], mnx, mxx);
        if (mag(xo) <= tolerance) return;
        yo = span_overlap(rb[1], rb[3], mny, mxy);
        if (mag(yo) <= tolerance) return;
        hit = 1;
        if (mag(xo) <= mag(yo)) begin
            push = -xo; axis = 0;
        end else begin
            push = -yo; axis = 1;
        end
    endtask

    task automatic predict_collisions(input t_req q);
        longint r1[4], c1[2], rt1[2], ex[4], ey[4];
        longint p0, p1, ov, c, s, sg, px, py, nx, ny, u;
        longint unsigned rsum, adx, ady;
        int a0, a1, axis, first_new;
        bit hit;
        t_expected e;
        if (q.first_of_set) table_count = 0;
        if (table_count >= MAX_BOXES) return;
        first_new = collisions_due.size();
        c1 = '{longint'(q.pivot_x), longint'(q.pivot_y)};
        r1[0] = clampv(longint'(q.min_x) - c1[0], -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        r1[1] = clampv(longint'(q.min_y) - c1[1], -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        r1[2] = clampv(longint'(q.max_x) - c1[0], -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        r1[3] = clampv(longint'(q.max_y) - c1[1], -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        rt1 = '{longint'(q.cos_angle), longint'(q.sin_angle)};
        for (int i = 0; i < table_count; i++) begin
            if (q.immovable && tbl_imm[i]) continue;
            rsum = tbl_rad[i] + longint'(q.bound_radius);
            adx = mag(c1[0] - tbl_c[i][0]);
            ady = mag(c1[1] - tbl_c[i][1]);
            if (adx >= rsum || ady >= rsum) continue;
            if (ady * ady >= rsum * rsum - adx * adx) continue;
            corners_in_frame(tbl_r[i], tbl_c[i], tbl_rt[i], c1, rt1, ex, ey);
            axis_overlap(r1, ex, ey, hit, p0, a0);
            if (!hit) continue;
            corners_in_frame(r1, c1, rt1, tbl_c[i], tbl_rt[i], ex, ey);
            axis_overlap(tbl_r[i], ex, ey, hit, p1, a1);
            if (!hit) continue;
            if (mag(p0) <= mag(p1)) begin
                ov = p0; axis = a0; c = rt1[0]; s = rt1[1]; sg = -1;
            end else begin
                ov = p1; axis = a1; c = tbl_rt[i][0]; s = tbl_rt[i][1]; sg = 1;
            end
            u = ov < 0 ? -1 : 1;
            if (axis == 0) begin
                px = floor14(ov * c + 8192); py = floor14(ov * s + 8192);
                nx = u * c; ny = u * s;
            end else begin
                px = floor14(-ov * s + 8192); py = floor14(ov * c + 8192);
                nx = -u * s; ny = u * c;
            end
            e.res.earlier  = tbl_entity[i];
            e.res.newer    = q.entity_id;
            e.res.push_x   = 32'(clampv(sg * px, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
            e.res.push_y   = 32'(clampv(sg * py, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
            e.res.normal_x = 16'(clampv(sg * nx, -16384, 16384));
            e.res.normal_y = 16'(clampv(sg * ny, -16384, 16384));
            e.res.depth    = 31'(clampv(mag(ov), 0, 64'h7FFF_FFFF));
            e.last = 1'b0;
            collisions_due = {collisions_due, e};
        end
        if (collisions_due.size() > first_new)
            collisions_due[collisions_due.size() - 1].last = 1'b1;
        tbl_entity[table_count] = q.entity_id;
        tbl_imm[table_count] = q.immovable;
        tbl_c[table_count] = c1;
        tbl_r[table_count] = r1;
        tbl_rt[table_count] = rt1;
        tbl_rad[table_count] = longint'(q.bound_radius);
        table_count++;
    endtask

    task automatic random_gap();
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            box_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_box(input t_req q);
        box_ch.valid <= 1'b1;
        box_ch.first_of_set <= q.first_of_set;
        box_ch.entity_id <= q.entity_id;
        box_ch.immovable <= q.immovable;
        box_ch.pivot_x <= q.pivot_x;
        box_ch.pivot_y <= q.pivot_y;
        box_ch.min_x <= q.min_x;
        box_ch.min_y <= q.min_y;
        box_ch.max_x <= q.max_x;
        box_ch.max_y <= q.max_y;
        box_ch.cos_angle <= q.cos_angle;
        box_ch.sin_angle <= q.sin_angle;
        box_ch.bound_radius <= q.bound_radius;
        do @(posedge i_clk); while (!box_ch.ready);
        predict_collisions(q);
        random_gap();
    endtask

    task automatic wait_drained();
        box_ch.valid <= 1'b0;
        do @(posedge i_clk);
        while ((collisions_due.size() != 0 || !box_ch.ready) && !timed_out);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [15:0] v);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tolerance = v;
    endtask

    function automatic t_req make_box(input bit first, input bit dense);
        t_req q;
        int signed ang;
        int signed spread;
        spread = dense ? 32'h0008_0000 : 32'h7FFF_0000;
        q.first_of_set = first;
        q.entity_id = 16'($urandom);
        q.immovable = ($urandom_range(0, 3) == 0);
        q.pivot_x = $signed($urandom_range(0, 2 * spread)) - spread;
        q.pivot_y = $signed($urandom_range(0, 2 * spread)) - spread;
        q.min_x = q.pivot_x - $urandom_range(0, 32'h0004_0000);
        q.min_y = q.pivot_y - $urandom_range(0, 32'h0004_0000);
        q.max_x = q.pivot_x + $urandom_range(0, 32'h0004_0000);
        q.max_y = q.pivot_y + $urandom_range(0, 32'h0004_0000);
        ang = $urandom_range(0, 7);
        case ($urandom_range(0, 3))
            0: begin q.cos_angle = 16'sd16384; q.sin_angle = '0; end
            1: begin
                q.cos_angle = 16'sd11585;
                q.sin_angle = ang[0] ? -16'sd11585 : 16'sd11585;
            end
            2: begin
                q.cos_angle = 16'sd14189;
                q.sin_angle = ang[1] ? -16'sd8192 : 16'sd8192;
            end
            default: begin
                q.cos_angle = 16'($signed($urandom_range(0, 32768)) - 16384);
                q.sin_angle = 16'($signed($urandom_range(0, 32768)) - 16384);
            end
        endcase
        q.bound_radius = 31'(dense ? $urandom_range(32'h0004_0000, 32'h0010_0000) : $urandom);
        if (!dense && $urandom_range(0, 3) == 0) begin
            q.min_x = $urandom; q.min_y = $urandom; q.max_x = $urandom; q.max_y = $urandom;
        end
        return q;
    endfunction

    task automatic test_directed();
        t_req q;
        q = '0;
        q.first_of_set = 1; q.entity_id = 16'h0000; q.cos_angle = 16'sd16384;
        q.min_x = -32'sh0001_0000; q.min_y = -32'sh0001_0000;
        q.max_x = 32'sh0001_0000; q.max_y = 32'sh0001_0000;
        q.bound_radius = 31'h0002_0000;
        send_box(q);
        // Overlapping square, then an immovable pair on the same pivot and extents.
        q.first_of_set = 0; q.entity_id = 16'hFFFF; q.pivot_x = 32'sh0000_8000;
        q.min_x += 32'sh0000_8000; q.max_x += 32'sh0000_8000;
        send_box(q);
        q.entity_id = 16'h1234; q.immovable = 1;
        q.cos_angle = 16'sd11585; q.sin_angle = 16'sd11585;
        send_box(q);
        q.entity_id = 16'h4321; q.cos_angle = -16'sd16384; q.sin_angle = 16'sd16384;
        send_box(q);
        q.immovable = 0; q.cos_angle = '0; q.sin_angle = -16'sd16384; q.entity_id = 16'h5555;
        send_box(q);
        // Touching edges: zero overlap.
        q.cos_angle = 16'sd16384; q.sin_angle = '0; q.pivot_x = 32'sh0002_0000;
        q.min_x = 32'sh0001_0000; q.max_x = 32'sh0003_0000; q.entity_id = 16'hAAAA;
        send_box(q);
        // Extreme coordinates and radius, saturating the relative corners.
        q.pivot_x = 32'sh7FFF_FFFF; q.pivot_y = -32'sh8000_0000;
        q.min_x = -32'sh8000_0000; q.min_y = 32'sh7FFF_FFFF;
        q.max_x = 32'sh7FFF_FFFF; q.max_y = -32'sh8000_0000;
        q.bound_radius = 31'h7FFF_FFFF; q.entity_id = 16'h0F0F;
        send_box(q);
        q.pivot_x = -32'sh8000_0000; q.pivot_y = 32'sh7FFF_FFFF; q.entity_id = 16'hF0F0;
        q.min_x = 32'sh7FFF_FFFF; q.min_y = -32'sh8000_0000;
        q.max_x = -32'sh8000_0000; q.max_y = 32'sh7FFF_FFFF;
        send_box(q);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < MAX_BOXES + 3; i++) send_box(make_box(i == 0, 1));
    endtask

    task automatic test_tolerance();
        write_tolerance(16'hFFFF);
        for (int i = 0; i < 20; i++) send_box(make_box(i == 0, 1));
        write_tolerance(16'h0100);
        for (int i = 0; i < 20; i++) send_box(make_box(i == 0, 1));
        write_tolerance(16'h0000);
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        for (int i = 0; i < 12; i++) send_box(make_box(i == 0, 1));
        wait_drained();
    endtask

    task automatic test_random();
        for (int i = 0; i < 200; i++) begin
            send_box(make_box($urandom_range(0, 11) == 0, $urandom_range(0, 4) != 0));
            if (i == 100) wait_drained();
        end
        quiet_mode = 1;
        for (int i = 0; i < 25; i++) send_box(make_box(i == 0, 1));
    endtask

    // Result sink: random stalls, with one long hold-off on request.
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (collisions_due.size() == 0) begin
                $error("unexpected result: earlier %0h newer %0h",
                       res_ch.earlier_entity, res_ch.newer_entity);
                errors++;
            end else begin
                t_expected e;
                e = collisions_due.pop_front();
                if (res_ch.earlier_entity !== e.res.earlier) begin
                    $error("earlier_entity exp %0h got %0h", e.res.earlier, res_ch.earlier_entity);
                    errors++;
                end
                if (res_ch.newer_entity !== e.res.newer) begin
                    $error("newer_entity exp %0h got %0h", e.res.newer, res_ch.newer_entity);
                    errors++;
                end
                if (res_ch.push_x !== e.res.push_x) begin
                    $error("push_x exp %0d got %0d", e.res.push_x, res_ch.push_x);
                    errors++;
                end
                if (res_ch.push_y !== e.res.push_y) begin
                    $error("push_y exp %0d got %0d", e.res.push_y, res_ch.push_y);
                    errors++;
                end
                if (res_ch.normal_x !== e.res.normal_x) begin
                    $error("normal_x exp %0d got %0d", e.res.normal_x, res_ch.normal_x);
                    errors++;
                end
                if (res_ch.normal_y !== e.res.normal_y) begin
                    $error("normal_y exp %0d got %0d", e.res.normal_y, res_ch.normal_y);
                    errors++;
                end
                if (res_ch.depth !== e.res.depth) begin
                    $error("depth exp %0d got %0d", e.res.depth, res_ch.depth);
                    errors++;
                end
                if (res_ch.last !== e.last) begin
                    $error("last exp %0b got %0b", e.last, res_ch.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            timed_out = 1;
            $display("oriented_box_pair_collision regression: fail");
            $finish;
        end
    end

    initial begin
        box_ch.valid <= 1'b0;
        box_ch.first_of_set <= 1'b0;
        box_ch.entity_id <= '0;
        box_ch.immovable <= 1'b0;
        box_ch.pivot_x <= '0;
        box_ch.pivot_y <= '0;
        box_ch.min_x <= '0;
        box_ch.min_y <= '0;
        box_ch.max_x <= '0;
        box_ch.max_y <= '0;
        box_ch.cos_angle <= '0;
        box_ch.sin_angle <= '0;
        box_ch.bound_radius <= '0;
        tolerance = 0;
        table_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_tolerance();
        test_backpressure();
        test_random();
        wait_drained();
        if (errors == 0)
            $display("oriented_box_pair_collision regression: pass");
        else
            $display("oriented_box_pair_collision regression: fail");
        $finish;
    end
endmodule
